// ===== design/gjri_pkg.sv =====
// Shared types and constants for the Gauss-Jordan row reduction block.
// Holds the sequencer state type, register indexes, mode and status codes.
// No dependencies.
`timescale 1ns / 1ps

package gjri_pkg;

  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] FX_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] FX_MIN = 32'sh80000000;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_COLS = 2'd2;

  // modes
  localparam logic [1:0] MODE_REF  = 2'd0;
  localparam logic [1:0] MODE_RREF = 2'd1;
  localparam logic [1:0] MODE_INV  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SING = 2'd1;
  localparam logic [1:0] STAT_NSQ  = 2'd2;

  typedef enum logic [28:0] {
    S_LOAD  = 29'h1 << 0,
    S_CRD   = 29'h1 << 1,
    S_CWR   = 29'h1 << 2,
    S_ID    = 29'h1 << 3,
    S_TOP   = 29'h1 << 4,
    S_SR    = 29'h1 << 5,
    S_SC    = 29'h1 << 6,
    S_SW0   = 29'h1 << 7,
    S_SW1   = 29'h1 << 8,
    S_SW2   = 29'h1 << 9,
    S_SW3   = 29'h1 << 10,
    S_NCHK  = 29'h1 << 11,
    S_NR    = 29'h1 << 12,
    S_NDS   = 29'h1 << 13,
    S_NDW   = 29'h1 << 14,
    S_EL0   = 29'h1 << 15,
    S_EL1   = 29'h1 << 16,
    S_RS0   = 29'h1 << 17,
    S_RS1   = 29'h1 << 18,
    S_RS2   = 29'h1 << 19,
    S_POST  = 29'h1 << 20,
    S_UPB   = 29'h1 << 21,
    S_UPR   = 29'h1 << 22,
    S_UPC   = 29'h1 << 23,
    S_UPI   = 29'h1 << 24,
    S_UPK   = 29'h1 << 25,
    S_ORD   = 29'h1 << 26,
    S_OCAP  = 29'h1 << 27,
    S_OHOLD = 29'h1 << 28
  } state_t;

endpackage

// ===== design/gjri_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gjri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== design/gjri_div.sv =====
// Iterative fixed-point divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// One quotient bit per cycle. Depends on gjri_pkg.
`timescale 1ns / 1ps

module gjri_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [gjri_pkg::DATA_W-1:0]  num,
  input  logic signed [gjri_pkg::DATA_W-1:0]  den,
  output logic                                done,
  output logic signed [gjri_pkg::DATA_W-1:0]  quo
);

  localparam int NW   = gjri_pkg::DATA_W + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [NW-1:0]   nq_r, nq_nxt;
  logic [31:0]     den_r, den_nxt;
  logic            neg_r, neg_nxt;

  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_step;
  logic [31:0] num_mag, den_mag;

  assign num_mag  = num[31] ? 32'(-num) : 32'(num);
  assign den_mag  = den[31] ? 32'(-den) : 32'(den);
  assign rem_sh   = {rem_r[31:0], nq_r[NW-1]};
  assign ge       = rem_sh >= {1'b0, den_r};
  assign rem_step = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(NW);
      rem_nxt  = '0;
      nq_nxt   = {num_mag, {FRAC_BITS{1'b0}}};
      den_nxt  = den_mag;
      neg_nxt  = num[31] ^ den[31];
    end else if (busy_r) begin
      rem_nxt = rem_step;
      nq_nxt  = {nq_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // sign and saturate the magnitude quotient
  always_comb begin
    if (!neg_r) begin
      quo = (nq_r > NW'(32'h7fffffff)) ? gjri_pkg::FX_MAX : $signed(nq_r[31:0]);
    end else begin
      quo = (nq_r > NW'(32'h80000000)) ? gjri_pkg::FX_MIN : $signed(32'(-nq_r[31:0]));
    end
  end

  assign done = done_r;

endmodule

// ===== design/gauss_jordan_row_reduce_inverse.sv =====
// Gauss-Jordan row reduction / inverse. Load: one element per cycle, no stall until the
// last element. Compute: about n^3 shared-unit steps; each row-subtract element passes
// through read, multiply and write states; each division runs the bit-serial divider over
// NW = 32 + FRAC_BITS quotient bits. Output: each element is read, captured and held until
// taken. One matrix at a time. Reset (synchronous, rst_n low): sequencer to load, load
// count zero, registers to mode 0 / 8 rows / 8 cols. Matrix memories are not cleared.
`timescale 1ns / 1ps

module gauss_jordan_row_reduce_inverse #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [gjri_pkg::DATA_W-1:0] in_element_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [gjri_pkg::DATA_W-1:0] out_result_value,
  output logic [1:0]                         out_status,
  output logic                               out_last_element,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [3:0]                         cfg_data
);

  localparam int IW  = $clog2(MAX_DIM);          // row index bits
  localparam int CW  = $clog2(2 * MAX_DIM);      // column index bits (augmented)
  localparam int DW  = $clog2(MAX_DIM + 1);      // row/col count bits
  localparam int EW  = CW + 1;                   // augmented column count bits
  localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
  localparam int LW  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int MAW = IW + CW;

  localparam logic signed [31:0] FX_ONE = 32'(64'd1 << FRAC_BITS);

  // ---------------------------------------------------------------- config
  logic [1:0] cfg_mode_r;
  logic [3:0] cfg_rows_r, cfg_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r <= gjri_pkg::MODE_REF;
      cfg_rows_r <= 4'd8;
      cfg_cols_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gjri_pkg::CFG_MODE: cfg_mode_r <= cfg_data[1:0];
        gjri_pkg::CFG_ROWS: cfg_rows_r <= cfg_data;
        gjri_pkg::CFG_COLS: cfg_cols_r <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Clamp sizes to 1..MAX_DIM; unused mode code acts as row echelon.
  logic [DW-1:0] rows_e, cols_e, rows_m1, cols_m1;
  logic [EW-1:0] ecols, ecols_m1;
  logic [LW-1:0] total;
  logic [1:0]    mode_e;

  assign rows_e = (cfg_rows_r == 4'd0) ? DW'(1) :
                  ({1'b0, cfg_rows_r} > 5'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg_rows_r);
  assign cols_e = (cfg_cols_r == 4'd0) ? DW'(1) :
                  ({1'b0, cfg_cols_r} > 5'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg_cols_r);
  assign rows_m1 = rows_e - DW'(1);
  assign cols_m1 = cols_e - DW'(1);
  assign mode_e  = (cfg_mode_r == gjri_pkg::MODE_RREF || cfg_mode_r == gjri_pkg::MODE_INV)
                   ? cfg_mode_r : gjri_pkg::MODE_REF;
  assign ecols    = (mode_e == gjri_pkg::MODE_INV) ? EW'({cols_e, 1'b0}) : EW'(cols_e);
  assign ecols_m1 = ecols - EW'(1);
  assign total    = LW'(rows_e * cols_e);

  function automatic logic [MAW-1:0] maddr(input logic [DW-1:0] r, input logic [EW-1:0] c);
    return {r[IW-1:0], c[CW-1:0]};
  endfunction

  // ---------------------------------------------------------------- memories
  // Input store keeps the loaded matrix for the copy-in and for echo; work store holds the
  // (augmented) matrix being reduced, addressed {row, col}.
  logic              in_we;
  logic [AW-1:0]     in_waddr, in_raddr;
  logic signed [31:0] in_rd;

  logic              m_we;
  logic [MAW-1:0]    m_waddr, m_raddr;
  logic signed [31:0] m_wdata, m_rd;

  gjri_ram #(.WIDTH(gjri_pkg::DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_element_value),
    .raddr (in_raddr),
    .rdata (in_rd)
  );

  gjri_ram #(.WIDTH(gjri_pkg::DATA_W), .DEPTH(1 << MAW)) u_work_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rd)
  );

  // ---------------------------------------------------------------- shared units
  logic signed [31:0] piv_val_r, piv_val_nxt, k_r, k_nxt, a_r, a_nxt, b_r, b_nxt;
  logic               div_start, div_done;
  logic signed [31:0] div_q;

  gjri_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (m_rd),
    .den   (piv_val_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // Row update y - k*x: registered product, then floor shift, saturate, subtract.
  logic signed [63:0] prod_r, prod_nxt, prod_w, prod_sh;
  logic signed [31:0] prod_sat, sub_sat;
  logic signed [32:0] diff;

  assign prod_w   = k_r * m_rd;
  assign prod_sh  = prod_r >>> FRAC_BITS;
  assign prod_sat = (prod_sh > 64'sh7fffffff) ? gjri_pkg::FX_MAX :
                    (prod_sh < -64'sh80000000) ? gjri_pkg::FX_MIN : prod_sh[31:0];
  assign diff     = {m_rd[31], m_rd} - {prod_sat[31], prod_sat};
  assign sub_sat  = (diff[32] != diff[31]) ? (diff[32] ? gjri_pkg::FX_MIN : gjri_pkg::FX_MAX)
                                           : diff[31:0];

  // ---------------------------------------------------------------- sequencer
  gjri_pkg::state_t state_r, state_nxt;
  logic [LW-1:0] lc_r, lc_nxt, lin_r, lin_nxt, lc_eff;
  logic [DW-1:0] i_r, i_nxt, top_r, top_nxt, pr_r, pr_nxt;
  logic [EW-1:0] j_r, j_nxt, pc_r, pc_nxt;
  logic          fail_r, fail_nxt, echo_r, echo_nxt, ret_up_r, ret_up_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;

  assign lc_eff = (lc_r >= total) ? '0 : lc_r;

  always_comb begin
    state_nxt     = state_r;
    lc_nxt        = lc_r;
    lin_nxt       = lin_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    top_nxt       = top_r;
    pr_nxt        = pr_r;
    pc_nxt        = pc_r;
    piv_val_nxt   = piv_val_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    fail_nxt      = fail_r;
    echo_nxt      = echo_r;
    ret_up_nxt    = ret_up_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_value_nxt = out_value_r;
    prod_nxt      = prod_r;
    in_we         = 1'b0;
    in_waddr      = lc_eff[AW-1:0];
    in_raddr      = lin_r[AW-1:0];
    m_we          = 1'b0;
    m_waddr       = '0;
    m_wdata       = '0;
    m_raddr       = '0;
    div_start     = 1'b0;

    unique case (state_r)
      gjri_pkg::S_LOAD: begin
        if (in_valid) begin
          in_we = 1'b1;
          if (LW'(lc_eff + 1'b1) == total) begin
            // last element in: start the reduction, or echo a non-square inverse input
            lc_nxt     = '0;
            lin_nxt    = '0;
            i_nxt      = '0;
            j_nxt      = '0;
            top_nxt    = '0;
            fail_nxt   = 1'b0;
            echo_nxt   = 1'b0;
            ret_up_nxt = 1'b0;
            status_nxt = gjri_pkg::STAT_OK;
            if (mode_e == gjri_pkg::MODE_INV && rows_e != cols_e) begin
              echo_nxt   = 1'b1;
              status_nxt = gjri_pkg::STAT_NSQ;
              state_nxt  = gjri_pkg::S_ORD;
            end else begin
              state_nxt = gjri_pkg::S_CRD;
            end
          end else begin
            lc_nxt = LW'(lc_eff + 1'b1);
          end
        end
      end

      gjri_pkg::S_CRD: state_nxt = gjri_pkg::S_CWR;

      gjri_pkg::S_CWR: begin
        m_we      = 1'b1;
        m_waddr   = maddr(i_r, j_r);
        m_wdata   = in_rd;
        lin_nxt   = lin_r + LW'(1);
        state_nxt = gjri_pkg::S_CRD;
        if (j_r == EW'(cols_m1)) begin
          j_nxt = '0;
          if (i_r == rows_m1) begin
            i_nxt     = '0;
            state_nxt = (mode_e == gjri_pkg::MODE_INV) ? gjri_pkg::S_ID : gjri_pkg::S_TOP;
          end else begin
            i_nxt = i_r + DW'(1);
          end
        end else begin
          j_nxt = j_r + EW'(1);
        end
      end

      gjri_pkg::S_ID: begin
        // fill the identity half of the augmented matrix
        m_we    = 1'b1;
        m_waddr = maddr(i_r, EW'(cols_e) + j_r);
        m_wdata = (EW'(i_r) == j_r) ? FX_ONE : '0;
        if (j_r == EW'(cols_m1)) begin
          j_nxt = '0;
          if (i_r == rows_m1) begin
            i_nxt     = '0;
            state_nxt = gjri_pkg::S_TOP;
          end else begin
            i_nxt = i_r + DW'(1);
          end
        end else begin
          j_nxt = j_r + EW'(1);
        end
      end

      gjri_pkg::S_TOP: begin
        if (top_r == rows_e) begin
          state_nxt = gjri_pkg::S_POST;
        end else begin
          i_nxt     = top_r;
          j_nxt     = '0;
          state_nxt = gjri_pkg::S_SR;
        end
      end

      gjri_pkg::S_SR: begin
        m_raddr   = maddr(i_r, j_r);
        state_nxt = gjri_pkg::S_SC;
      end

      gjri_pkg::S_SC: begin
        // column-first pivot search
        if (m_rd != 0) begin
          pr_nxt      = i_r;
          pc_nxt      = j_r;
          piv_val_nxt = m_rd;
          j_nxt       = '0;
          state_nxt   = (i_r != top_r) ? gjri_pkg::S_SW0 : gjri_pkg::S_NCHK;
        end else if (i_r == rows_m1) begin
          i_nxt = top_r;
          if (j_r == ecols_m1) begin
            fail_nxt  = 1'b1;  // no pivot left: stop reducing
            state_nxt = gjri_pkg::S_POST;
          end else begin
            j_nxt     = j_r + EW'(1);
            state_nxt = gjri_pkg::S_SR;
          end
        end else begin
          i_nxt     = i_r + DW'(1);
          state_nxt = gjri_pkg::S_SR;
        end
      end

      gjri_pkg::S_SW0: begin
        m_raddr   = maddr(pr_r, j_r);
        state_nxt = gjri_pkg::S_SW1;
      end

      gjri_pkg::S_SW1: begin
        m_raddr   = maddr(top_r, j_r);
        a_nxt     = m_rd;
        state_nxt = gjri_pkg::S_SW2;
      end

      gjri_pkg::S_SW2: begin
        m_we      = 1'b1;
        m_waddr   = maddr(top_r, j_r);
        m_wdata   = a_r;
        b_nxt     = m_rd;
        state_nxt = gjri_pkg::S_SW3;
      end

      gjri_pkg::S_SW3: begin
        m_we    = 1'b1;
        m_waddr = maddr(pr_r, j_r);
        m_wdata = b_r;
        if (j_r == ecols_m1) begin
          j_nxt     = '0;
          state_nxt = gjri_pkg::S_NCHK;
        end else begin
          j_nxt     = j_r + EW'(1);
          state_nxt = gjri_pkg::S_SW0;
        end
      end

      gjri_pkg::S_NCHK: begin
        if (EW'(top_r) != pc_r) begin
          fail_nxt = 1'b1;  // pivot off the diagonal
        end
        if (piv_val_r == FX_ONE) begin
          i_nxt     = top_r + DW'(1);
          state_nxt = gjri_pkg::S_EL0;
        end else begin
          j_nxt     = '0;
          state_nxt = gjri_pkg::S_NR;
        end
      end

      gjri_pkg::S_NR: begin
        m_raddr   = maddr(top_r, j_r);
        state_nxt = gjri_pkg::S_NDS;
      end

      gjri_pkg::S_NDS: begin
        div_start = 1'b1;
        state_nxt = gjri_pkg::S_NDW;
      end

      gjri_pkg::S_NDW: begin
        if (div_done) begin
          m_we    = 1'b1;
          m_waddr = maddr(top_r, j_r);
          m_wdata = (j_r == pc_r) ? FX_ONE : div_q;
          if (j_r == ecols_m1) begin
            i_nxt     = top_r + DW'(1);
            state_nxt = gjri_pkg::S_EL0;
          end else begin
            j_nxt     = j_r + EW'(1);
            state_nxt = gjri_pkg::S_NR;
          end
        end
      end

      gjri_pkg::S_EL0: begin
        if (i_r == rows_e) begin
          top_nxt   = top_r + DW'(1);
          state_nxt = gjri_pkg::S_TOP;
        end else begin
          m_raddr   = maddr(i_r, pc_r);
          state_nxt = gjri_pkg::S_EL1;
        end
      end

      gjri_pkg::S_EL1: begin
        k_nxt = m_rd;
        if (m_rd == 0) begin
          i_nxt     = i_r + DW'(1);
          state_nxt = gjri_pkg::S_EL0;
        end else begin
          j_nxt     = '0;
          state_nxt = gjri_pkg::S_RS0;
        end
      end

      // row i -= k * row top
      gjri_pkg::S_RS0: begin
        m_raddr   = maddr(top_r, j_r);
        state_nxt = gjri_pkg::S_RS1;
      end

      gjri_pkg::S_RS1: begin
        m_raddr   = maddr(i_r, j_r);
        prod_nxt  = prod_w;
        state_nxt = gjri_pkg::S_RS2;
      end

      gjri_pkg::S_RS2: begin
        m_we    = 1'b1;
        m_waddr = maddr(i_r, j_r);
        m_wdata = sub_sat;
        if (j_r == ecols_m1) begin
          j_nxt     = '0;
          i_nxt     = i_r + DW'(1);
          state_nxt = ret_up_r ? gjri_pkg::S_UPI : gjri_pkg::S_EL0;
        end else begin
          j_nxt     = j_r + EW'(1);
          state_nxt = gjri_pkg::S_RS0;
        end
      end

      gjri_pkg::S_POST: begin
        lin_nxt = '0;
        i_nxt   = '0;
        j_nxt   = '0;
        if (mode_e == gjri_pkg::MODE_INV && fail_r) begin
          echo_nxt   = 1'b1;
          status_nxt = gjri_pkg::STAT_SING;
          state_nxt  = gjri_pkg::S_ORD;
        end else if (mode_e == gjri_pkg::MODE_REF) begin
          state_nxt = gjri_pkg::S_ORD;
        end else begin
          top_nxt    = rows_m1;
          ret_up_nxt = 1'b1;
          state_nxt  = gjri_pkg::S_UPB;
        end
      end

      gjri_pkg::S_UPB: begin
        j_nxt = '0;
        if (top_r == '0) begin
          i_nxt     = '0;
          state_nxt = gjri_pkg::S_ORD;
        end else begin
          state_nxt = gjri_pkg::S_UPR;
        end
      end

      gjri_pkg::S_UPR: begin
        m_raddr   = maddr(top_r, j_r);
        state_nxt = gjri_pkg::S_UPC;
      end

      gjri_pkg::S_UPC: begin
        // leading entry of the bottom row
        if (m_rd != 0) begin
          pc_nxt    = j_r;
          i_nxt     = '0;
          state_nxt = gjri_pkg::S_UPI;
        end else if (j_r == ecols_m1) begin
          top_nxt   = top_r - DW'(1);
          state_nxt = gjri_pkg::S_UPB;
        end else begin
          j_nxt     = j_r + EW'(1);
          state_nxt = gjri_pkg::S_UPR;
        end
      end

      gjri_pkg::S_UPI: begin
        if (i_r == top_r) begin
          top_nxt   = top_r - DW'(1);
          state_nxt = gjri_pkg::S_UPB;
        end else begin
          m_raddr   = maddr(i_r, pc_r);
          state_nxt = gjri_pkg::S_UPK;
        end
      end

      gjri_pkg::S_UPK: begin
        k_nxt = m_rd;
        if (m_rd == 0) begin
          i_nxt     = i_r + DW'(1);
          state_nxt = gjri_pkg::S_UPI;
        end else begin
          j_nxt     = '0;
          state_nxt = gjri_pkg::S_RS0;
        end
      end

      gjri_pkg::S_ORD: begin
        m_raddr   = maddr(i_r, ((mode_e == gjri_pkg::MODE_INV) ? EW'(cols_e) : '0) + j_r);
        state_nxt = gjri_pkg::S_OCAP;
      end

      gjri_pkg::S_OCAP: begin
        out_value_nxt = echo_r ? in_rd : m_rd;
        out_last_nxt  = (lin_r == total - LW'(1));
        out_valid_nxt = 1'b1;
        state_nxt     = gjri_pkg::S_OHOLD;
      end

      gjri_pkg::S_OHOLD: begin
        // hold the result until the transfer completes
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          lin_nxt       = lin_r + LW'(1);
          if (out_last_r) begin
            state_nxt = gjri_pkg::S_LOAD;
          end else begin
            state_nxt = gjri_pkg::S_ORD;
            if (j_r == EW'(cols_m1)) begin
              j_nxt = '0;
              i_nxt = i_r + DW'(1);
            end else begin
              j_nxt = j_r + EW'(1);
            end
          end
        end
      end

      default: state_nxt = gjri_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gjri_pkg::S_LOAD;
      lc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lin_r       <= lin_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    top_r       <= top_nxt;
    pr_r        <= pr_nxt;
    pc_r        <= pc_nxt;
    piv_val_r   <= piv_val_nxt;
    k_r         <= k_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    fail_r      <= fail_nxt;
    echo_r      <= echo_nxt;
    ret_up_r    <= ret_up_nxt;
    status_r    <= status_nxt;
    out_last_r  <= out_last_nxt;
    out_value_r <= out_value_nxt;
    prod_r      <= prod_nxt;
  end

  assign in_stall         = (state_r != gjri_pkg::S_LOAD);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = status_r;
  assign out_last_element = out_last_r;

`ifndef ASSERT_OFF
  // a result is only offered from the hold state
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == gjri_pkg::S_OHOLD))
    else $error("result valid outside hold state");

  // never take input while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input accepted while result pending");

  // divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == gjri_pkg::S_NDW))
    else $error("divider done outside wait state");

  // after the final result transfer, return to loading
  a_last_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_element) |=> !in_stall)
    else $error("not ready after last result");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for gauss_jordan_row_reduce_inverse: echelon, reduced echelon, inverse.
// Keeps its own fixed-point row-reduction predictor; needs gjri_pkg and the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int DIM  = 8;
  localparam int FRAC = 16;
  localparam int ONE  = 1 << FRAC;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_element_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic [1:0]         out_status;
  logic               out_last_element;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = gjri_pkg::CFG_MODE;
  logic [3:0]         cfg_data = '0;

  gauss_jordan_row_reduce_inverse u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_element_value(in_element_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_value(out_result_value),
    .out_status(out_status), .out_last_element(out_last_element),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Predictor state: our copy of registers and loaded elements
  logic [1:0] mode_reg = gjri_pkg::MODE_REF;
  logic [3:0] rows_reg = 4'd8;
  logic [3:0] cols_reg = 4'd8;
  int         loaded[2*DIM*DIM];
  int         load_cnt = 0;
  int         mat[DIM][2*DIM];
  int         pivot_col[DIM];

  result_t    pending_results[$];
  int         errors = 0;
  int         long_hold = 0;
  int         items_sent = 0;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // Exact product, floor shift, saturate
  function automatic int fx_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> FRAC);
  endfunction

  // Truncating division, saturate
  function automatic int fx_div(int x, int p);
    longint num;
    num = longint'(x) <<< FRAC;
    return sat32(num / longint'(p));
  endfunction

  function automatic void row_sub(int cols, int src, int dst, int k);
    for (int j = 0; j < cols; j++)
      mat[dst][j] = sat32(longint'(mat[dst][j]) - longint'(fx_mul(k, mat[src][j])));
  endfunction

  function automatic int echelon(int rows, int cols);
    bit found;
    int pr, pc, lead, tmp;
    for (int top = 0; top < rows; top++) begin
      found = 0;
      pr = top;
      pc = 0;
      for (int j = 0; j < cols && !found; j++)
        for (int i = top; i < rows && !found; i++)
          if (mat[i][j] != 0) begin
            found = 1; pr = i; pc = j;
          end
      if (!found) return top;
      if (pr != top)
        for (int j = 0; j < 2*DIM; j++) begin
          tmp = mat[pr][j]; mat[pr][j] = mat[top][j]; mat[top][j] = tmp;
        end
      lead = mat[top][pc];
      if (lead != ONE) begin
        for (int j = 0; j < cols; j++) mat[top][j] = fx_div(mat[top][j], lead);
        mat[top][pc] = ONE;
      end
      for (int i = top + 1; i < rows; i++)
        if (mat[i][pc] != 0) row_sub(cols, top, i, mat[i][pc]);
      pivot_col[top] = pc;
    end
    return rows;
  endfunction

  function automatic void reduce_upward(int rows, int cols);
    int j;
    for (int b = rows - 1; b > 0; b--) begin
      j = 0;
      while (j < cols && mat[b][j] == 0) j++;
      if (j < cols)
        for (int i = 0; i < b; i++) row_sub(cols, b, i, mat[i][j]);
    end
  endfunction

  function automatic int clamp_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  // Absorb one accepted element; on the last one queue the whole result matrix
  function automatic void predict_matrix(logic signed [31:0] elem);
    int rows, cols, total, np, n;
    logic [1:0] md, stat;
    bit echo;
    result_t r;
    rows  = clamp_dim(rows_reg);
    cols  = clamp_dim(cols_reg);
    total = rows * cols;
    md    = (mode_reg == gjri_pkg::MODE_RREF || mode_reg == gjri_pkg::MODE_INV)
            ? mode_reg : gjri_pkg::MODE_REF;
    stat  = gjri_pkg::STAT_OK;
    echo  = 0;
    if (load_cnt >= total) load_cnt = 0;
    loaded[load_cnt] = elem;
    load_cnt++;
    if (load_cnt < total) return;
    load_cnt = 0;
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < 2*DIM; j++)
        mat[i][j] = (i < rows && j < cols) ? loaded[i*cols + j] : 0;
    if (md == gjri_pkg::MODE_INV) begin
      if (rows != cols) begin
        echo = 1; stat = gjri_pkg::STAT_NSQ;
      end else begin
        for (int i = 0; i < rows; i++)
          for (int j = 0; j < cols; j++) mat[i][cols + j] = (i == j) ? ONE : 0;
        np = echelon(rows, 2*cols);
        if (np < rows) echo = 1;
        for (int i = 0; i < np && !echo; i++)
          if (pivot_col[i] != i) echo = 1;
        if (echo) stat = gjri_pkg::STAT_SING;
        else reduce_upward(rows, 2*cols);
      end
    end else begin
      np = echelon(rows, cols);
      if (md == gjri_pkg::MODE_RREF) reduce_upward(rows, cols);
    end
    n = 0;
    for (int i = 0; i < rows; i++)
      for (int j = 0; j < cols; j++) begin
        if (echo) r.value = loaded[i*cols + j];
        else if (md == gjri_pkg::MODE_INV) r.value = mat[i][cols + j];
        else r.value = mat[i][j];
        r.status = stat;
        r.last   = (n + 1 == total);
        pending_results.push_back(r);
        n++;
      end
  endfunction

  // Send one element after a random gap; valid is left high so a zero-gap
  // follow-up keeps it asserted without a second assignment in the same step.
  task automatic send_element(logic signed [31:0] elem, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= elem;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_matrix(elem);
    items_sent++;
  endtask

  // Drop valid and hold until every expected result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges, only with the block idle
  task automatic set_config(logic [1:0] md, logic [3:0] rows, logic [3:0] cols);
    drain();
    cfg_we <= 1'b1; cfg_index <= gjri_pkg::CFG_MODE; cfg_data <= {2'b00, md};
    @(posedge clk);
    mode_reg = md;
    cfg_index <= gjri_pkg::CFG_ROWS; cfg_data <= rows;
    @(posedge clk);
    rows_reg = rows;
    cfg_index <= gjri_pkg::CFG_COLS; cfg_data <= cols;
    @(posedge clk);
    cols_reg = cols;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_element();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) return '0;
    if (pick < 12) return ($signed($urandom_range(0, 8)) - 4) * ONE;
    if (pick < 15) return $signed($urandom_range(0, 2*ONE)) - ONE;
    if (pick < 16) return ($urandom_range(0, 1) == 1) ? gjri_pkg::FX_MAX : gjri_pkg::FX_MIN;
    return $urandom();
  endfunction

  task automatic send_matrix(int count);
    for (int k = 0; k < count; k++) send_element(rand_element());
  endtask

  task automatic test_single_elements();
    set_config(gjri_pkg::MODE_REF, 4'd1, 4'd1);
    send_element(32'sd0);
    send_element(gjri_pkg::FX_MIN);
    send_element(gjri_pkg::FX_MAX);
    set_config(gjri_pkg::MODE_RREF, 4'd1, 4'd1);
    send_element(-3 * ONE);
    set_config(gjri_pkg::MODE_INV, 4'd1, 4'd1);
    send_element(2 * ONE);
    send_element(32'sd0);          // singular: echoed
    send_element(32'sd1);          // tiny pivot, reciprocal saturates
  endtask

  task automatic test_shapes();
    set_config(gjri_pkg::MODE_INV, 4'd2, 4'd3);        // not square: echoed
    send_matrix(6);
    set_config(2'd3, 4'd2, 4'd2);            // unused mode acts as echelon
    send_element(32'sd0); send_element(ONE); send_element(2 * ONE);
    send_element(gjri_pkg::FX_MAX);
    set_config(gjri_pkg::MODE_RREF, 4'd0, 4'd15);      // zero rows -> 1, oversize cols -> 8
    send_matrix(8);
  endtask

  task automatic test_mid_load_resize();
    set_config(gjri_pkg::MODE_REF, 4'd2, 4'd2);
    send_matrix(3);
    set_config(gjri_pkg::MODE_RREF, 4'd1, 4'd2);       // three loaded >= two: restart load
    send_matrix(2);
    set_config(gjri_pkg::MODE_REF, 4'd2, 4'd2);
    send_matrix(1);
    set_config(gjri_pkg::MODE_INV, 4'd2, 4'd2);        // one loaded < four: keep going
    send_element(gjri_pkg::FX_MAX); send_element(gjri_pkg::FX_MIN); send_element(ONE);
  endtask

  task automatic test_backpressure();
    set_config(gjri_pkg::MODE_INV, 4'd2, 4'd2);
    long_hold = 400;                         // receiver sits still while input backs up
    for (int k = 0; k < 8; k++) send_element(rand_element(), 1);
  endtask

  task automatic test_random();
    int r, c;
    set_config(gjri_pkg::MODE_INV, 4'd8, 4'd8);        // one full-size inverse, diagonally dominant
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        send_element((i == j) ? 9 * ONE : $signed($urandom_range(0, 2*ONE)) - ONE);
    while (items_sent < 130) begin
      r = $urandom_range(1, 4);
      c = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : r;
      set_config(2'($urandom_range(0, 3)), 4'(r), 4'(c));
      send_matrix(r * c);
    end
  endtask

  // Result side: random hold-offs, compare every transfer with the oldest expectation
  initial begin
    int hold;
    result_t exp_r;
    forever begin
      if (long_hold > 0) begin
        hold = long_hold;
        long_hold = 0;
      end else begin
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d last=%0b", $realtime,
                 out_result_value, out_status, out_last_element);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_value !== exp_r.value || out_status !== exp_r.status ||
            out_last_element !== exp_r.last) begin
          $display("%0t: mismatch expected value=%h status=%0d last=%0b, actual value=%h status=%0d last=%0b",
                   $realtime, exp_r.value, exp_r.status, exp_r.last,
                   out_result_value, out_status, out_last_element);
          errors++;
        end
      end
    end
  end

  initial begin
    #(50_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_elements();
    test_shapes();
    test_mid_load_resize();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
